FILE: hw/rtl/lsss_pkg.sv
// ----------------------------------------------------------------------------
// lsss_pkg
// Shared types and codes for the light and sound scene selector.
// ----------------------------------------------------------------------------
package lsss_pkg;

    localparam int LEVEL_W = 10;
    localparam int BRIGHT_W = 8;
    localparam int ANIM_W = 2;
    localparam int SCENE_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_HYST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOUND_MID  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOUND_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOUND_HYST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_MAX = 3'd5;

    // reset values
    localparam logic [LEVEL_W-1:0]  RST_LIGHT_THR  = 10'd400;
    localparam logic [LEVEL_W-1:0]  RST_LIGHT_HYST = 10'd80;
    localparam logic [LEVEL_W-1:0]  RST_SOUND_MID  = 10'd250;
    localparam logic [LEVEL_W-1:0]  RST_SOUND_HIGH = 10'd550;
    localparam logic [LEVEL_W-1:0]  RST_SOUND_HYST = 10'd60;
    localparam logic [BRIGHT_W-1:0] RST_BRIGHT_MAX = 8'd120;

    // max*3/5 as (max*615) >> 10, exact for every 8-bit max
    localparam int THREE_FIFTHS_MUL = 615;
    localparam int THREE_FIFTHS_SHIFT = 10;

    localparam logic [ANIM_W-1:0] ANIM_OFF       = 2'd0;
    localparam logic [ANIM_W-1:0] ANIM_STATIC    = 2'd1;
    localparam logic [ANIM_W-1:0] ANIM_BREATHING = 2'd2;
    localparam logic [ANIM_W-1:0] ANIM_PULSE     = 2'd3;

    localparam logic [SCENE_W-1:0] SCENE_UNOCCUPIED = 3'd0;
    localparam logic [SCENE_W-1:0] SCENE_BRIGHT     = 3'd1;
    localparam logic [SCENE_W-1:0] SCENE_SOFT       = 3'd2;
    localparam logic [SCENE_W-1:0] SCENE_MEDIUM     = 3'd3;
    localparam logic [SCENE_W-1:0] SCENE_PARTY      = 3'd4;

    typedef enum logic [1:0] {
        BAND_LOW  = 2'd0,
        BAND_MID  = 2'd1,
        BAND_HIGH = 2'd2
    } band_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]  light_thr;
        logic [LEVEL_W-1:0]  light_hyst;
        logic [LEVEL_W-1:0]  sound_mid;
        logic [LEVEL_W-1:0]  sound_high;
        logic [LEVEL_W-1:0]  sound_hyst;
        logic [BRIGHT_W-1:0] bright_max;
        logic [BRIGHT_W-1:0] bright_quarter;
        logic [BRIGHT_W-1:0] bright_three_fifths;
    } cfg_t;

    typedef struct packed {
        logic                is_dark;
        logic [BRIGHT_W-1:0] brightness;
        logic [ANIM_W-1:0]   animation;
        logic [SCENE_W-1:0]  scene;
        logic                lamp_on;
    } result_t;

endpackage

FILE: hw/rtl/lsss_cfg_regs.sv
// ----------------------------------------------------------------------------
// lsss_cfg_regs
// Configuration registers, with the scaled brightness levels worked out
// when the maximum is written.
// ----------------------------------------------------------------------------
module lsss_cfg_regs
    import lsss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic [BRIGHT_W-1:0] new_max;
    logic [BRIGHT_W+THREE_FIFTHS_SHIFT-1:0] scaled;

    assign new_max = cfg_data[BRIGHT_W-1:0];
    assign scaled = (BRIGHT_W+THREE_FIFTHS_SHIFT)'(new_max)
                  * (BRIGHT_W+THREE_FIFTHS_SHIFT)'(THREE_FIFTHS_MUL);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_LIGHT_THR:  cfg_next.light_thr  = cfg_data;
                REG_LIGHT_HYST: cfg_next.light_hyst = cfg_data;
                REG_SOUND_MID:  cfg_next.sound_mid  = cfg_data;
                REG_SOUND_HIGH: cfg_next.sound_high = cfg_data;
                REG_SOUND_HYST: cfg_next.sound_hyst = cfg_data;
                REG_BRIGHT_MAX:
                begin
                    cfg_next.bright_max = new_max;
                    cfg_next.bright_quarter = new_max >> 2;
                    cfg_next.bright_three_fifths =
                        scaled[THREE_FIFTHS_SHIFT +: BRIGHT_W];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.light_thr  <= RST_LIGHT_THR;
            cfg_reg.light_hyst <= RST_LIGHT_HYST;
            cfg_reg.sound_mid  <= RST_SOUND_MID;
            cfg_reg.sound_high <= RST_SOUND_HIGH;
            cfg_reg.sound_hyst <= RST_SOUND_HYST;
            cfg_reg.bright_max <= RST_BRIGHT_MAX;
            cfg_reg.bright_quarter <= RST_BRIGHT_MAX >> 2;
            cfg_reg.bright_three_fifths <= BRIGHT_W'(
                (int'(RST_BRIGHT_MAX) * THREE_FIFTHS_MUL) >> THREE_FIFTHS_SHIFT);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/lsss_classify.sv
// ----------------------------------------------------------------------------
// lsss_classify
// Schmitt rules for the dark flag and the sound band, and the scene lookup.
// ----------------------------------------------------------------------------
module lsss_classify
    import lsss_pkg::*;
(
    input  cfg_t               cfg,
    input  logic               occupied,
    input  logic [LEVEL_W-1:0] light_level,
    input  logic [LEVEL_W-1:0] sound_level,
    input  logic               dark,
    input  band_t              band,
    output logic               dark_next,
    output band_t              band_next,
    output result_t            result
);

    logic [LEVEL_W:0] light_upper;
    logic [LEVEL_W:0] sound_plus_hyst;
    logic             light_low;
    logic             light_high;
    logic             dark_new;
    logic             snd_ge_high;
    logic             snd_ge_mid;
    logic             drop_high;
    logic             drop_mid;
    band_t            band_new;

    // compare level + hyst against threshold so a negative difference never wraps
    assign light_upper = {1'b0, cfg.light_thr} + {1'b0, cfg.light_hyst};
    assign sound_plus_hyst = {1'b0, sound_level} + {1'b0, cfg.sound_hyst};
    assign light_low  = light_level < cfg.light_thr;
    assign light_high = {1'b0, light_level} > light_upper;
    assign snd_ge_high = sound_level >= cfg.sound_high;
    assign snd_ge_mid  = sound_level >= cfg.sound_mid;
    assign drop_high = sound_plus_hyst < {1'b0, cfg.sound_high};
    assign drop_mid  = sound_plus_hyst < {1'b0, cfg.sound_mid};

    always_comb
    begin
        if (light_low)
            dark_new = 1'b1;
        else if (light_high)
            dark_new = 1'b0;
        else
            dark_new = dark;

        case (band)
            BAND_HIGH:
            begin
                if (!drop_high)
                    band_new = BAND_HIGH;
                else if (drop_mid)
                    band_new = BAND_LOW;
                else
                    band_new = BAND_MID;
            end
            BAND_MID:
            begin
                if (snd_ge_high)
                    band_new = BAND_HIGH;
                else if (drop_mid)
                    band_new = BAND_LOW;
                else
                    band_new = BAND_MID;
            end
            default:
            begin
                if (snd_ge_high)
                    band_new = BAND_HIGH;
                else if (snd_ge_mid)
                    band_new = BAND_MID;
                else
                    band_new = BAND_LOW;
            end
        endcase
    end

    always_comb
    begin
        dark_next = dark;
        band_next = band;
        result.is_dark = dark;
        result.brightness = '0;
        result.animation = ANIM_OFF;
        result.scene = SCENE_UNOCCUPIED;
        if (occupied)
        begin
            dark_next = dark_new;
            result.is_dark = dark_new;
            if (!dark_new)
            begin
                result.scene = SCENE_BRIGHT;
            end
            else
            begin
                band_next = band_new;
                case (band_new)
                    BAND_LOW:
                    begin
                        result.brightness = cfg.bright_quarter;
                        result.animation = ANIM_STATIC;
                        result.scene = SCENE_SOFT;
                    end
                    BAND_MID:
                    begin
                        result.brightness = cfg.bright_three_fifths;
                        result.animation = ANIM_BREATHING;
                        result.scene = SCENE_MEDIUM;
                    end
                    default:
                    begin
                        result.brightness = cfg.bright_max;
                        result.animation = ANIM_PULSE;
                        result.scene = SCENE_PARTY;
                    end
                endcase
            end
        end
        result.lamp_on = |result.brightness;
    end

endmodule

FILE: hw/rtl/light_sound_scene_selector.sv
// ----------------------------------------------------------------------------
// light_sound_scene_selector
// Picks lamp brightness, animation and scene from occupancy, light and sound,
// with hysteresis on the dark flag and on the three sound bands.
// ----------------------------------------------------------------------------
// One result beat per input beat. A beat waits in the input register, where
// its result is worked out against the current dark flag and sound band; both
// are updated as the beat moves on into the result register, where it sits
// until taken. With no stall on the output a new beat is accepted every cycle,
// and its result is offered from the edge after acceptance. A stalled output
// lets one more beat into the input register before the input stalls too.
// Configuration writes take effect at the next edge and should only be made
// while no beat is in flight.
module light_sound_scene_selector
    import lsss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  occupied,
    input  logic [LEVEL_W-1:0]    light_level,
    input  logic [LEVEL_W-1:0]    sound_level,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  is_dark,
    output logic [BRIGHT_W-1:0]   brightness,
    output logic [ANIM_W-1:0]     animation,
    output logic [SCENE_W-1:0]    scene,
    output logic                  lamp_on
);

    cfg_t    cfg;
    logic    s1_valid_reg;
    logic    occupied_reg;
    logic [LEVEL_W-1:0] light_reg;
    logic [LEVEL_W-1:0] sound_reg;
    logic    dark_reg;
    logic    dark_next;
    band_t   band_reg;
    band_t   band_next;
    result_t result_next;
    result_t result_reg;
    logic    out_valid_reg;
    logic    s1_move;
    logic    in_take;

    lsss_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsss_classify u_classify (
        .cfg         (cfg),
        .occupied    (occupied_reg),
        .light_level (light_reg),
        .sound_level (sound_reg),
        .dark        (dark_reg),
        .band        (band_reg),
        .dark_next   (dark_next),
        .band_next   (band_next),
        .result      (result_next)
    );

    // input stage moves on when the result register is free or being drained
    assign s1_move  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_move;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            dark_reg      <= 1'b0;
            band_reg      <= BAND_LOW;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (s1_move)
                out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg && s1_move)
            begin
                dark_reg <= dark_next;
                band_reg <= band_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            occupied_reg <= occupied;
            light_reg    <= light_level;
            sound_reg    <= sound_level;
        end
        if (s1_valid_reg && s1_move)
            result_reg <= result_next;
    end

    assign out_valid  = out_valid_reg;
    assign is_dark    = result_reg.is_dark;
    assign brightness = result_reg.brightness;
    assign animation  = result_reg.animation;
    assign scene      = result_reg.scene;
    assign lamp_on    = result_reg.lamp_on;

endmodule

FILE: hw/rtl/lsss_checker.sv
// ----------------------------------------------------------------------------
// lsss_checker
// Port-level checks on the scene selector, bound to the top level.
// ----------------------------------------------------------------------------
module lsss_checker
    import lsss_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic                  is_dark,
    input logic [BRIGHT_W-1:0]   brightness,
    input logic [ANIM_W-1:0]     animation,
    input logic [SCENE_W-1:0]    scene,
    input logic                  lamp_on
);

    // a held result beat keeps its brightness, scene, animation and dark flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(brightness)
            && $stable(scene) && $stable(animation) && $stable(is_dark))
        else $error("result beat changed while stalled");

    // input only backs up when the output is backed up
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    a_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> lamp_on == (brightness != '0))
        else $error("lamp_on disagrees with brightness");

    a_anim_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((scene == SCENE_UNOCCUPIED || scene == SCENE_BRIGHT)
            == (animation == ANIM_OFF)))
        else $error("animation does not match scene");

    a_dark_scene: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scene != SCENE_UNOCCUPIED |->
            is_dark == (scene != SCENE_BRIGHT))
        else $error("scene does not match dark flag");

endmodule

bind light_sound_scene_selector lsss_checker u_lsss_checker (.*);

FILE: tb/light_sound_scene_selector_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_sound_scene_selector_checker
// Watches the configuration port and both beat channels of the scene
// selector, keeps its own dark flag and sound band, predicts every result
// beat and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module light_sound_scene_selector_checker
    import lsss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  occupied,
    input  logic [LEVEL_W-1:0]    light_level,
    input  logic [LEVEL_W-1:0]    sound_level,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  is_dark,
    input  logic [BRIGHT_W-1:0]   brightness,
    input  logic [ANIM_W-1:0]     animation,
    input  logic [SCENE_W-1:0]    scene,
    input  logic                  lamp_on,
    output int                    fail_count,
    output int                    pending
);

    logic [LEVEL_W-1:0]  light_thr;
    logic [LEVEL_W-1:0]  light_hyst;
    logic [LEVEL_W-1:0]  sound_mid;
    logic [LEVEL_W-1:0]  sound_high;
    logic [LEVEL_W-1:0]  sound_hyst;
    logic [BRIGHT_W-1:0] bright_max;
    logic                dark_flag;
    band_t               band;
    result_t             scene_q[$];

    function automatic band_t next_band(input band_t cur, input int lvl);
        int mid_i;
        int high_i;
        int hyst_i;
        mid_i  = int'(sound_mid);
        high_i = int'(sound_high);
        hyst_i = int'(sound_hyst);
        // falling out of high re-enters the medium rule in the same step
        if (cur == BAND_HIGH) begin
            if (lvl < high_i - hyst_i)
                cur = BAND_MID;
            else
                return BAND_HIGH;
        end
        if (cur == BAND_MID) begin
            if (lvl >= high_i)
                return BAND_HIGH;
            if (lvl < mid_i - hyst_i)
                return BAND_LOW;
            return BAND_MID;
        end
        if (lvl >= high_i)
            return BAND_HIGH;
        if (lvl >= mid_i)
            return BAND_MID;
        return BAND_LOW;
    endfunction

    task automatic predict_scene(input logic occ, input int lvl_light, input int lvl_sound);
        result_t r;
        int      scaled;
        r = '0;
        r.animation = ANIM_OFF;
        r.scene = SCENE_UNOCCUPIED;
        if (occ) begin
            if (lvl_light < int'(light_thr))
                dark_flag = 1'b1;
            else if (lvl_light > int'(light_thr) + int'(light_hyst))
                dark_flag = 1'b0;
            if (!dark_flag) begin
                r.scene = SCENE_BRIGHT;
            end
            else begin
                band = next_band(band, lvl_sound);
                case (band)
                    BAND_LOW:
                    begin
                        scaled = int'(bright_max) / 4;
                        r.animation = ANIM_STATIC;
                        r.scene = SCENE_SOFT;
                    end
                    BAND_MID:
                    begin
                        scaled = (int'(bright_max) * 3) / 5;
                        r.animation = ANIM_BREATHING;
                        r.scene = SCENE_MEDIUM;
                    end
                    default:
                    begin
                        scaled = int'(bright_max);
                        r.animation = ANIM_PULSE;
                        r.scene = SCENE_PARTY;
                    end
                endcase
                r.brightness = scaled[BRIGHT_W-1:0];
            end
        end
        r.is_dark = dark_flag;
        r.lamp_on = (r.brightness != '0);
        scene_q.push_back(r);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n) begin
            light_thr  = RST_LIGHT_THR;
            light_hyst = RST_LIGHT_HYST;
            sound_mid  = RST_SOUND_MID;
            sound_high = RST_SOUND_HIGH;
            sound_hyst = RST_SOUND_HYST;
            bright_max = RST_BRIGHT_MAX;
            dark_flag  = 1'b0;
            band       = BAND_LOW;
            scene_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_LIGHT_THR:  light_thr  = cfg_data;
                    REG_LIGHT_HYST: light_hyst = cfg_data;
                    REG_SOUND_MID:  sound_mid  = cfg_data;
                    REG_SOUND_HIGH: sound_high = cfg_data;
                    REG_SOUND_HYST: sound_hyst = cfg_data;
                    REG_BRIGHT_MAX: bright_max = cfg_data[BRIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (scene_q.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    fail_count++;
                end
                else begin
                    want = scene_q.pop_front();
                    check_field("is_dark", int'(want.is_dark), int'(is_dark));
                    check_field("brightness", int'(want.brightness), int'(brightness));
                    check_field("animation", int'(want.animation), int'(animation));
                    check_field("scene", int'(want.scene), int'(scene));
                    check_field("lamp_on", int'(want.lamp_on), int'(lamp_on));
                end
            end
            if (in_valid && !in_stall)
                predict_scene(occupied, int'(light_level), int'(sound_level));
            pending = scene_q.size();
        end
    end

endmodule

FILE: tb/light_sound_scene_selector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_sound_scene_selector_tb
// Drives occupancy, light and sound beats into the scene selector under
// several register settings and handshake mixes; the checker beside the
// block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module light_sound_scene_selector_tb;
    import lsss_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_BEATS = 140;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  occupied = 1'b0;
    logic [LEVEL_W-1:0]    light_level = '0;
    logic [LEVEL_W-1:0]    sound_level = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  is_dark;
    logic [BRIGHT_W-1:0]   brightness;
    logic [ANIM_W-1:0]     animation;
    logic [SCENE_W-1:0]    scene;
    logic                  lamp_on;

    int fail_count;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int beats_sent = 0;
    int settings_used = 1;
    int quiet_cycles = 0;

    // copies of the registers, used only to aim the random levels
    int light_thr_now  = int'(RST_LIGHT_THR);
    int light_hyst_now = int'(RST_LIGHT_HYST);
    int sound_mid_now  = int'(RST_SOUND_MID);
    int sound_high_now = int'(RST_SOUND_HIGH);
    int sound_hyst_now = int'(RST_SOUND_HYST);

    always #2 clk = ~clk;

    light_sound_scene_selector DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .occupied    (occupied),
        .light_level (light_level),
        .sound_level (sound_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_dark     (is_dark),
        .brightness  (brightness),
        .animation   (animation),
        .scene       (scene),
        .lamp_on     (lamp_on)
    );

    light_sound_scene_selector_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .occupied    (occupied),
        .light_level (light_level),
        .sound_level (sound_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_dark     (is_dark),
        .brightness  (brightness),
        .animation   (animation),
        .scene       (scene),
        .lamp_on     (lamp_on),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog on cycles with no beat moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("light_sound_scene_selector_tb: FAIL");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_LIGHT_THR:  light_thr_now  = int'(val);
            REG_LIGHT_HYST: light_hyst_now = int'(val);
            REG_SOUND_MID:  sound_mid_now  = int'(val);
            REG_SOUND_HIGH: sound_high_now = int'(val);
            REG_SOUND_HYST: sound_hyst_now = int'(val);
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_scene(input logic occ, input logic [LEVEL_W-1:0] lt,
                              input logic [LEVEL_W-1:0] snd);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        occupied    <= occ;
        light_level <= lt;
        sound_level <= snd;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
    endtask

    // lower valid and let every result drain before touching registers
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [LEVEL_W-1:0] near_level(input int centre, input int spread);
        int v;
        v = centre - spread + int'($urandom_range(0, 2 * spread));
        if (v < 0)
            v = 0;
        else if (v > 1023)
            v = 1023;
        return v[LEVEL_W-1:0];
    endfunction

    task automatic random_beats(input int count);
        logic               occ;
        logic [LEVEL_W-1:0] lt;
        logic [LEVEL_W-1:0] snd;
        for (int i = 0; i < count; i++) begin
            occ = ($urandom_range(0, 9) != 0);
            // mostly dark rooms, so the sound bands get exercised
            case ($urandom_range(0, 3))
                0:       lt = LEVEL_W'($urandom_range(0, 1023));
                1:       lt = near_level(light_thr_now, light_hyst_now + 16);
                default: lt = near_level(light_thr_now - 60, 60);
            endcase
            case ($urandom_range(0, 3))
                0:       snd = LEVEL_W'($urandom_range(0, 1023));
                1:       snd = near_level(sound_mid_now, sound_hyst_now + 16);
                2:       snd = near_level(sound_high_now, sound_hyst_now + 16);
                default: snd = near_level(sound_high_now - sound_hyst_now, 20);
            endcase
            send_scene(occ, lt, snd);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: unoccupied, bright room, both hysteresis bands
        send_scene(1'b0, 10'd0, 10'd0);
        send_scene(1'b0, 10'd1023, 10'd1023);
        send_scene(1'b1, 10'd1023, 10'd0);
        send_scene(1'b1, 10'd440, 10'd600);
        send_scene(1'b1, 10'd399, 10'd0);
        send_scene(1'b1, 10'd480, 10'd1023);
        send_scene(1'b1, 10'd0, 10'd491);
        send_scene(1'b1, 10'd0, 10'd489);
        send_scene(1'b1, 10'd0, 10'd190);
        send_scene(1'b1, 10'd0, 10'd189);
        send_scene(1'b1, 10'd0, 10'd249);
        send_scene(1'b1, 10'd0, 10'd250);
        send_scene(1'b1, 10'd0, 10'd550);
        // high straight down to low in one beat
        send_scene(1'b1, 10'd0, 10'd0);
        send_scene(1'b0, 10'd1023, 10'd1023);
        send_scene(1'b1, 10'd400, 10'd700);
        send_scene(1'b1, 10'd481, 10'd700);
        drain();

        // top of every register, brightness max taken from the low byte
        write_reg(REG_LIGHT_THR, 10'd1023);
        write_reg(REG_LIGHT_HYST, 10'd1023);
        write_reg(REG_SOUND_MID, 10'd1023);
        write_reg(REG_SOUND_HIGH, 10'd1023);
        write_reg(REG_SOUND_HYST, 10'd1023);
        write_reg(REG_BRIGHT_MAX, 10'h3FF);
        // indexes past the last register must be ignored
        write_reg(3'd6, 10'd0);
        write_reg(3'd7, 10'd0);
        settings_used++;
        send_scene(1'b1, 10'd1022, 10'd1022);
        send_scene(1'b1, 10'd0, 10'd1023);
        send_scene(1'b1, 10'd0, 10'd0);
        send_scene(1'b1, 10'd1023, 10'd1023);
        drain();

        // small brightness maximum: the quarter level rounds down to zero, three fifths to one
        write_reg(REG_BRIGHT_MAX, 10'd3);
        write_reg(REG_SOUND_HIGH, 10'd600);
        write_reg(REG_SOUND_MID, 10'd300);
        write_reg(REG_SOUND_HYST, 10'd0);
        settings_used++;
        send_scene(1'b1, 10'd0, 10'd0);
        send_scene(1'b1, 10'd0, 10'd300);
        send_scene(1'b1, 10'd0, 10'd600);
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0:
                begin
                    write_reg(REG_LIGHT_THR, RST_LIGHT_THR);
                    write_reg(REG_LIGHT_HYST, RST_LIGHT_HYST);
                    write_reg(REG_SOUND_MID, RST_SOUND_MID);
                    write_reg(REG_SOUND_HIGH, RST_SOUND_HIGH);
                    write_reg(REG_SOUND_HYST, RST_SOUND_HYST);
                    write_reg(REG_BRIGHT_MAX, CFG_DATA_W'(RST_BRIGHT_MAX));
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    write_reg(REG_LIGHT_THR, 10'd0);
                    write_reg(REG_LIGHT_HYST, 10'd0);
                    write_reg(REG_SOUND_MID, 10'd0);
                    write_reg(REG_SOUND_HIGH, 10'd0);
                    write_reg(REG_SOUND_HYST, 10'd0);
                    write_reg(REG_BRIGHT_MAX, 10'd0);
                    idle_pct = 86;
                    stall_pct = 0;
                end
                2:
                begin
                    // negative band edges and mid above high
                    write_reg(REG_LIGHT_THR, 10'd600);
                    write_reg(REG_LIGHT_HYST, 10'd0);
                    write_reg(REG_SOUND_MID, 10'd700);
                    write_reg(REG_SOUND_HIGH, 10'd300);
                    write_reg(REG_SOUND_HYST, 10'd900);
                    write_reg(REG_BRIGHT_MAX, 10'd2);
                    idle_pct = 0;
                    stall_pct = 86;
                end
                3:
                begin
                    write_reg(REG_LIGHT_THR, 10'd1000);
                    write_reg(REG_LIGHT_HYST, 10'd1000);
                    write_reg(REG_SOUND_MID, 10'd100);
                    write_reg(REG_SOUND_HIGH, 10'd1000);
                    write_reg(REG_SOUND_HYST, 10'd500);
                    write_reg(REG_BRIGHT_MAX, 10'd255);
                    idle_pct = 15;
                    stall_pct = 15;
                end
                default:
                begin
                    write_reg(REG_LIGHT_THR, CFG_DATA_W'($urandom_range(0, 1023)));
                    write_reg(REG_LIGHT_HYST, CFG_DATA_W'($urandom_range(0, 200)));
                    write_reg(REG_SOUND_MID, CFG_DATA_W'($urandom_range(0, 1023)));
                    write_reg(REG_SOUND_HIGH, CFG_DATA_W'($urandom_range(0, 1023)));
                    write_reg(REG_SOUND_HYST, CFG_DATA_W'($urandom_range(0, 200)));
                    write_reg(REG_BRIGHT_MAX, CFG_DATA_W'($urandom_range(0, 1023)));
                    idle_pct = $urandom_range(0, 60);
                    stall_pct = $urandom_range(0, 60);
                end
            endcase
            settings_used++;
            random_beats(PHASE_BEATS);
            drain();
        end

        repeat (10) @(posedge clk);
        $display("covered %0d input beats over %0d register settings,", beats_sent,
                 settings_used);
        $display("with sender gaps and receiver stalls from none up to 86 in a hundred");
        if (fail_count == 0 && pending == 0)
            $display("light_sound_scene_selector_tb: PASS");
        else
            $display("light_sound_scene_selector_tb: FAIL");
        $finish;
    end

endmodule
